/* rtl/prime_count_sieve_6k_defines.svh */
// Assertion macros for the prime_count_sieve_6k checker.
// Depends on nothing; each macro expects clk and rst_n in the scope where it is used.
`ifndef PRIME_COUNT_SIEVE_6K_DEFINES_SVH
`define PRIME_COUNT_SIEVE_6K_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define PSV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prime_count_sieve_6k: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define PSV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prime_count_sieve_6k: next-cycle check failed");

`endif

/* rtl/psv_pkg.sv */
// Shared types and constants of the 6k+-1 wheel sieve prime counter.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package psv_pkg;

    localparam int unsigned MAX_N_DEF = 65535;
    localparam int unsigned LIMIT_W   = 16;
    localparam int unsigned COUNT_W   = 13;
    localparam int unsigned DATA_W    = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the limit, reset the walk registers
        logic init_step;  // write one initial flag, advance v
        logic p_read;     // read the flag of p
        logic p_next;     // advance p to the next odd value
        logic m_start;    // set the first product of p
        logic m_step;     // clear the flag at m, advance m along the wheel
        logic cnt_start;  // set v to 2 for the count pass
        logic cnt_read;   // read the flag at v, advance v
        logic res_load;   // move the count into the output register
    } psv_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic init_last;  // v is the limit
        logic pp_over;    // p*p is above the limit
        logic p_flag;     // flag of p, valid the cycle after p_read
        logic m_over;     // product is above the limit
        logic n_small;    // limit below two
        logic cnt_last;   // v is the limit
        logic out_free;   // output register can take a new word
    } psv_sts_t;

endpackage

`default_nettype wire

/* rtl/psv_ctrl.sv */
// Controller state machine of the wheel sieve prime counter.
// Depends on psv_pkg; drives the datapath through psv_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module psv_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire psv_pkg::psv_sts_t sts,
    output psv_pkg::psv_cmd_t     cmd
);
    import psv_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_INIT   = 3'd1;
    localparam logic [2:0] ST_PTEST  = 3'd2;
    localparam logic [2:0] ST_PCHECK = 3'd3;
    localparam logic [2:0] ST_MARK   = 3'd4;
    localparam logic [2:0] ST_CNT    = 3'd5;
    localparam logic [2:0] ST_CDRAIN = 3'd6;
    localparam logic [2:0] ST_FINISH = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_last)
                    state_next = ST_PTEST;
            end
            ST_PTEST:
            begin
                if (sts.pp_over)
                begin
                    cmd.cnt_start = 1'b1;
                    state_next    = sts.n_small ? ST_CDRAIN : ST_CNT;
                end
                else
                begin
                    cmd.p_read = 1'b1;
                    state_next = ST_PCHECK;
                end
            end
            ST_PCHECK:
            begin
                if (sts.p_flag)
                begin
                    cmd.m_start = 1'b1;
                    state_next  = ST_MARK;
                end
                else
                begin
                    cmd.p_next = 1'b1;
                    state_next = ST_PTEST;
                end
            end
            ST_MARK:
            begin
                if (sts.m_over)
                begin
                    cmd.p_next = 1'b1;
                    state_next = ST_PTEST;
                end
                else
                    cmd.m_step = 1'b1;
            end
            ST_CNT:
            begin
                cmd.cnt_read = 1'b1;
                if (sts.cnt_last)
                    state_next = ST_CDRAIN;
            end
            ST_CDRAIN:
                state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

/* rtl/psv_dp.sv */
// Datapath of the wheel sieve prime counter: flag memory, walk counters, count and result.
// Depends on psv_pkg; obeys psv_cmd_t from psv_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module psv_dp #(
    parameter int unsigned MAX_N = psv_pkg::MAX_N_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [psv_pkg::LIMIT_W-1:0]   limit,
    input  wire psv_pkg::psv_cmd_t             cmd,
    output psv_pkg::psv_sts_t                  sts,
    output logic [psv_pkg::COUNT_W-1:0]        prime_count,
    output logic                               out_valid,
    input  wire logic                          out_ready
);
    import psv_pkg::*;

    localparam int unsigned NW = $clog2(MAX_N + 1);
    localparam int unsigned PW = NW + 2;
    localparam int unsigned LW = (NW > LIMIT_W) ? NW : LIMIT_W;

    logic mem [0:MAX_N];

    logic [NW-1:0]      n_reg;
    logic [NW-1:0]      v_reg;
    logic [2:0]         vmod_reg;
    logic [NW-1:0]      p_reg;
    logic [2:0]         pmod_reg;
    logic [PW-1:0]      pp_reg;
    logic [PW-1:0]      m_reg;
    logic               ph_reg;
    logic [NW-1:0]      cnt_reg;
    logic               pend_reg;
    logic               rd_reg;
    logic [COUNT_W-1:0] res_reg;
    logic               out_valid_reg;

    logic [LW-1:0]      lim_ext;
    logic [LW-1:0]      max_ext;
    logic [NW-1:0]      n_load;
    logic [PW-1:0]      p2;
    logic [PW-1:0]      p4;
    logic [NW-1:0]      addr;
    logic               we;
    logic               wdata;
    logic               init_flag;

    // Clamp the limit to the store depth
    assign lim_ext = LW'(limit);
    assign max_ext = LW'(MAX_N);
    assign n_load  = (lim_ext > max_ext) ? NW'(max_ext) : NW'(lim_ext);

    assign p2 = PW'({p_reg, 1'b0});
    assign p4 = PW'({p_reg, 2'b00});

    // 2 and 3, then 6k+1 and 6k+5 from 5 up
    assign init_flag = (v_reg == NW'(2)) || (v_reg == NW'(3))
                     || ((v_reg >= NW'(5)) && ((vmod_reg == 3'd1) || (vmod_reg == 3'd5)));

    always_comb
    begin
        addr  = v_reg;
        we    = 1'b0;
        wdata = 1'b0;
        priority if (cmd.init_step)
        begin
            we    = 1'b1;
            wdata = init_flag;
        end
        else if (cmd.m_step)
        begin
            addr = m_reg[NW-1:0];
            we   = 1'b1;
        end
        else if (cmd.p_read)
            addr = p_reg;
        else
            addr = v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rd_reg <= mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg    <= n_load;
            v_reg    <= '0;
            vmod_reg <= 3'd0;
            p_reg    <= NW'(3);
            pmod_reg <= 3'd3;
            pp_reg   <= PW'(9);
            cnt_reg  <= '0;
        end
        if (cmd.init_step)
        begin
            v_reg    <= v_reg + NW'(1);
            vmod_reg <= (vmod_reg == 3'd5) ? 3'd0 : vmod_reg + 3'd1;
        end
        if (cmd.p_next)
        begin
            // (p+2)^2 = p^2 + 4p + 4
            p_reg  <= p_reg + NW'(2);
            pp_reg <= pp_reg + p4 + PW'(4);
            unique case (pmod_reg)
                3'd1:    pmod_reg <= 3'd3;
                3'd3:    pmod_reg <= 3'd5;
                default: pmod_reg <= 3'd1;
            endcase
        end
        if (cmd.m_start)
        begin
            // p = 3 starts at q = 5; other p start at q = p
            m_reg  <= (pmod_reg == 3'd3) ? pp_reg + p2 : pp_reg;
            ph_reg <= (pmod_reg == 3'd1);
        end
        if (cmd.m_step)
        begin
            m_reg  <= m_reg + (ph_reg ? p4 : p2);
            ph_reg <= ~ph_reg;
        end
        if (cmd.cnt_start)
            v_reg <= NW'(2);
        if (cmd.cnt_read)
            v_reg <= v_reg + NW'(1);
        pend_reg <= cmd.cnt_read;
        if (pend_reg && rd_reg)
            cnt_reg <= cnt_reg + NW'(1);
        if (cmd.res_load)
            res_reg <= COUNT_W'(cnt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.res_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        sts.init_last = (v_reg == n_reg);
        sts.pp_over   = (pp_reg > PW'(n_reg));
        sts.p_flag    = rd_reg;
        sts.m_over    = (m_reg > PW'(n_reg));
        sts.n_small   = (n_reg < NW'(2));
        sts.cnt_last  = (v_reg == n_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign prime_count = res_reg;
    assign out_valid   = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/prime_count_sieve_6k.sv */
// Channel  Dir  Word  Fields (low bit up)
// s        in   16    limit[15:0]
// m        out  16    prime_count[12:0], zero[15:13]
//
// One limit n per run, n clamped to MAX_N.
// The flag memory is single-port: one access per cycle across fill, sieve and count.
// rst_n clears the controller and output valid; the flag store needs no clearing pass.
// The next limit is taken once the count is handed to the output register, even while
// that word still waits; a run that finishes with the word still held stalls until it leaves.
//
// Top level of the 6k+-1 wheel sieve prime counter.
// Depends on psv_pkg, psv_ctrl and psv_dp.
`timescale 1ns / 1ps
`default_nettype none

module prime_count_sieve_6k #(
    parameter int unsigned MAX_N = psv_pkg::MAX_N_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [psv_pkg::DATA_W-1:0]    s_tdata,   // limit[15:0]
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [psv_pkg::DATA_W-1:0]         m_tdata    // prime_count[12:0], zero[15:13]
);
    import psv_pkg::*;

    psv_cmd_t           cmd;
    psv_sts_t           sts;
    logic [COUNT_W-1:0] prime_count;

    // Sequence fill, sieve and count
    psv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold the flag store, walk counters and the output word
    psv_dp #(
        .MAX_N (MAX_N)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .limit       (s_tdata[LIMIT_W-1:0]),
        .cmd         (cmd),
        .sts         (sts),
        .prime_count (prime_count),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

    // Pad the count with zeros up to the word
    assign m_tdata = DATA_W'(prime_count);

endmodule

`default_nettype wire

/* rtl/psv_checker.sv */
// Port-level checker for prime_count_sieve_6k, bound to the top level below.
// Depends on prime_count_sieve_6k_defines.svh for its assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "prime_count_sieve_6k_defines.svh"

module psv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // A run is under way: no second limit right after one is taken
    `PSV_ASSERT_NEXT(a_one_run, s_tvalid && s_tready, !s_tready)

    // No result can appear the cycle after a limit is taken
    `PSV_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready && !m_tvalid, !m_tvalid)

    // A stalled result word holds
    `PSV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Padding bits of the result word stay zero
    `PSV_ASSERT_NOW(a_out_pad, m_tvalid, m_tdata[15:13] == 3'b000)

endmodule

bind prime_count_sieve_6k psv_checker u_psv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
